/* rtl/core/value_list_deframer_macros.svh */
// Assertion macros for the value list deframer checkers.
// Include with the bare file name; expects clk_i and rst_ni in scope.
`ifndef VALUE_LIST_DEFRAMER_MACROS_SVH
`define VALUE_LIST_DEFRAMER_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define VLD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Output holds while the result transfer is stalled.
`define VLD_ASSERT_HOLD(label, vld, rdy, sig, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (vld && !rdy) |=> (vld && $stable(sig))) else $error(msg);

`endif

/* rtl/core/vld_pkg.sv */
// Shared types and constants for the value list deframer.
// Used by vld_core, vld_rq, the top level and the checker; no dependencies.
`timescale 1ns / 1ps

package vld_pkg;

  localparam int unsigned LengthBitsDefault = 32;
  localparam int unsigned FieldBytes        = 4;
  localparam int unsigned FieldCntW         = $clog2(FieldBytes);
  localparam int unsigned ShiftW            = 8 * (FieldBytes - 1);
  // Result queue depth; a power of two, at least two.
  localparam int unsigned ResQDepth         = 4;

  typedef enum logic [2:0] {
    PH_MODE,
    PH_COUNT,
    PH_FSIZE,
    PH_FPAY,
    PH_VSIZE,
    PH_VPAY,
    PH_DONE
  } phase_e;

  typedef enum logic [2:0] {
    KIND_HEADER = 3'd0,
    KIND_BYTE   = 3'd1,
    KIND_EMPTY  = 3'd2,
    KIND_ACCEPT = 3'd3,
    KIND_ERROR  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NO_HEADER  = 3'd0,
    ERR_NO_FSIZE   = 3'd1,
    ERR_FPAY_SHORT = 3'd2,
    ERR_SIZE_SHORT = 3'd3,
    ERR_VPAY_SHORT = 3'd4,
    ERR_TRAILING   = 3'd5
  } err_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload_byte;
    logic [31:0] element_index;
    logic        element_end;
    logic [31:0] item_count;
    logic [31:0] fixed_size;
    logic        variable_mode;
    err_e        error_code;
    logic        last_result;
  } result_t;

  // Up to two results written per accepted item, first in order.
  typedef struct packed {
    logic [1:0] num;
    result_t    first;
    result_t    second;
  } res_wr_t;

  function automatic result_t blank_result(kind_e k);
    result_t r;
    r      = '0;
    r.kind = k;
    return r;
  endfunction

endpackage

/* rtl/core/value_list_deframer.sv */
// Top level of the value list deframer: parser plus result queue.
// Depends on vld_pkg, vld_core and vld_rq.
//
//   channel | handshake             | payload
//   --------+-----------------------+---------------------------------------------
//   in      | in_valid_i/in_ready_o | data_byte_i, blob_end_i, no_byte_i
//   out     | out_valid_o/out_ready_i | kind_o .. error_code_o, last_result_o
//
// One input item per cycle while in_ready_o is high; results enter the queue.
// An item gives up to two results; the output drains one result per transfer.
// A four-entry result queue parts the two sides; in_ready_o drops when fewer
// than two are free; the rate is one result per cycle while out_ready_i is high.
// Reset clears all parser state at once; no clearing pass is needed.
`timescale 1ns / 1ps

module value_list_deframer import vld_pkg::*; #(
  parameter int unsigned LENGTH_BITS = LengthBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        blob_end_i,
  input  logic        no_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [31:0] element_index_o,
  output logic        element_end_o,
  output logic [31:0] item_count_o,
  output logic [31:0] fixed_size_o,
  output logic        variable_mode_o,
  output logic [2:0]  error_code_o,
  output logic        last_result_o
);

  res_wr_t wr;
  result_t head;
  logic    accept;

  assign accept = in_valid_i && in_ready_o;

  vld_core #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .blob_end_i  (blob_end_i),
    .no_byte_i   (no_byte_i),
    .wr_o        (wr)
  );

  vld_rq u_rq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (wr),
    .space2_o    (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .head_o      (head)
  );

  assign kind_o          = head.kind;
  assign payload_byte_o  = head.payload_byte;
  assign element_index_o = head.element_index;
  assign element_end_o   = head.element_end;
  assign item_count_o    = head.item_count;
  assign fixed_size_o    = head.fixed_size;
  assign variable_mode_o = head.variable_mode;
  assign error_code_o    = head.error_code;
  assign last_result_o   = head.last_result;

endmodule

/* rtl/core/vld_rq.sv */
// Result queue: takes up to two results per cycle, gives one per transfer.
// Depends on vld_pkg.
`timescale 1ns / 1ps

module vld_rq import vld_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  res_wr_t wr_i,
  output logic    space2_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t head_o
);

  localparam int unsigned PtrW = $clog2(ResQDepth);
  localparam int unsigned CntW = $clog2(ResQDepth + 1);

  result_t             mem_q [ResQDepth];
  logic [PtrW-1:0]     wp_q, wp_d, rp_q, rp_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                pop;

  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  assign space2_o    = (cnt_q <= CntW'(ResQDepth - 2));
  assign head_o      = mem_q[rp_q];

  always_comb begin
    wp_d  = wp_q + PtrW'(wr_i.num);
    rp_d  = rp_q + PtrW'(pop);
    cnt_d = cnt_q + CntW'(wr_i.num) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.num != 2'd0) begin
      mem_q[wp_q] <= wr_i.first;
    end
    if (wr_i.num == 2'd2) begin
      mem_q[wp_q + PtrW'(1)] <= wr_i.second;
    end
  end

endmodule

/* rtl/core/vld_core.sv */
// Framing parser: at most one blob byte per accepted item, up to two results out.
// Depends on vld_pkg; results go to vld_rq.
`timescale 1ns / 1ps

module vld_core import vld_pkg::*; #(
  parameter int unsigned LENGTH_BITS = LengthBitsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] data_byte_i,
  input  logic       blob_end_i,
  input  logic       no_byte_i,
  output res_wr_t    wr_o
);

  phase_e                 phase_q, phase_d;
  logic [FieldCntW-1:0]   fcnt_q, fcnt_d;
  logic [ShiftW-1:0]      fshift_q, fshift_d;
  logic                   mvar_q, mvar_d;
  logic [LENGTH_BITS-1:0] count_q, count_d;
  logic [LENGTH_BITS-1:0] size_q, size_d;
  logic [LENGTH_BITS-1:0] done_q, done_d;
  logic [LENGTH_BITS-1:0] left_q, left_d;
  logic                   trail_q, trail_d;

  logic [8*FieldBytes-1:0] fld_full_word;
  logic [LENGTH_BITS-1:0]  fld_val;
  logic                    fld_last;
  logic [LENGTH_BITS-1:0]  done_inc;
  logic [LENGTH_BITS-1:0]  left_dec;
  logic                    has_byte_res;
  logic                    has_end_res;
  result_t                 byte_res;
  result_t                 end_res;

  assign fld_full_word = {data_byte_i, fshift_q};
  assign fld_val       = fld_full_word[LENGTH_BITS-1:0];
  assign fld_last      = (fcnt_q == FieldCntW'(FieldBytes - 1));
  assign done_inc      = done_q + LENGTH_BITS'(1);
  assign left_dec      = left_q - LENGTH_BITS'(1);

  always_comb begin
    phase_d      = phase_q;
    fcnt_d       = fcnt_q;
    fshift_d     = fshift_q;
    mvar_d       = mvar_q;
    count_d      = count_q;
    size_d       = size_q;
    done_d       = done_q;
    left_d       = left_q;
    trail_d      = trail_q;
    has_byte_res = 1'b0;
    has_end_res  = 1'b0;
    byte_res     = blank_result(KIND_HEADER);
    end_res      = blank_result(KIND_ACCEPT);

    if (accept_i && !no_byte_i) begin
      // Gather 32-bit little-endian fields; clear the gather on the last byte.
      if (phase_q == PH_COUNT || phase_q == PH_FSIZE || phase_q == PH_VSIZE) begin
        if (fld_last) begin
          fcnt_d   = '0;
          fshift_d = '0;
        end else begin
          fcnt_d   = fcnt_q + FieldCntW'(1);
          fshift_d = fshift_q | (ShiftW'(data_byte_i) << {fcnt_q, 3'b000});
        end
      end

      case (phase_q)
        PH_MODE: begin
          mvar_d   = (data_byte_i != 8'd0);
          fcnt_d   = '0;
          fshift_d = '0;
          phase_d  = PH_COUNT;
        end
        PH_COUNT: begin
          if (fld_last) begin
            count_d = fld_val;
            done_d  = '0;
            if (mvar_q) begin
              has_byte_res           = 1'b1;
              byte_res.item_count    = 32'(fld_val);
              byte_res.variable_mode = 1'b1;
              phase_d = (fld_val == '0) ? PH_DONE : PH_VSIZE;
            end else begin
              phase_d = PH_FSIZE;
            end
          end
        end
        PH_FSIZE: begin
          if (fld_last) begin
            size_d              = fld_val;
            has_byte_res        = 1'b1;
            byte_res.item_count = 32'(count_q);
            byte_res.fixed_size = 32'(fld_val);
            if (count_q == '0 || fld_val == '0) begin
              phase_d = PH_DONE;
            end else begin
              left_d  = fld_val;
              phase_d = PH_FPAY;
            end
          end
        end
        PH_FPAY, PH_VPAY: begin
          has_byte_res           = 1'b1;
          byte_res               = blank_result(KIND_BYTE);
          byte_res.payload_byte  = data_byte_i;
          byte_res.element_index = 32'(done_q);
          byte_res.element_end   = (left_dec == '0);
          left_d                 = left_dec;
          if (left_dec == '0) begin
            done_d = done_inc;
            if (phase_q == PH_FPAY) begin
              left_d = size_q;
            end
            if (done_inc == count_q) begin
              phase_d = PH_DONE;
            end else begin
              phase_d = (phase_q == PH_FPAY) ? PH_FPAY : PH_VSIZE;
            end
          end
        end
        PH_VSIZE: begin
          if (fld_last) begin
            if (fld_val == '0) begin
              has_byte_res           = 1'b1;
              byte_res               = blank_result(KIND_EMPTY);
              byte_res.element_index = 32'(done_q);
              byte_res.element_end   = 1'b1;
              done_d                 = done_inc;
              phase_d = (done_inc == count_q) ? PH_DONE : PH_VSIZE;
            end else begin
              left_d  = fld_val;
              phase_d = PH_VPAY;
            end
          end
        end
        default: begin
          trail_d = 1'b1;
        end
      endcase
    end

    if (accept_i && blob_end_i) begin
      has_end_res = 1'b1;
      end_res     = blank_result(KIND_ERROR);
      case (phase_d)
        PH_MODE, PH_COUNT: end_res.error_code = ERR_NO_HEADER;
        PH_FSIZE:          end_res.error_code = ERR_NO_FSIZE;
        PH_FPAY:           end_res.error_code = ERR_FPAY_SHORT;
        PH_VSIZE:          end_res.error_code = ERR_SIZE_SHORT;
        PH_VPAY:           end_res.error_code = ERR_VPAY_SHORT;
        default: begin
          if (trail_d) begin
            end_res.error_code = ERR_TRAILING;
          end else begin
            end_res = blank_result(KIND_ACCEPT);
          end
        end
      endcase
      // Return to the idle state for the next blob.
      phase_d  = PH_MODE;
      fcnt_d   = '0;
      fshift_d = '0;
      mvar_d   = 1'b0;
      count_d  = '0;
      size_d   = '0;
      done_d   = '0;
      left_d   = '0;
      trail_d  = 1'b0;
    end

    wr_o        = '0;
    wr_o.second = blank_result(KIND_HEADER);
    if (has_byte_res && has_end_res) begin
      wr_o.num                = 2'd2;
      wr_o.first              = byte_res;
      wr_o.second             = end_res;
      wr_o.second.last_result = 1'b1;
    end else if (has_byte_res) begin
      wr_o.num               = 2'd1;
      wr_o.first             = byte_res;
      wr_o.first.last_result = 1'b1;
    end else if (has_end_res) begin
      wr_o.num               = 2'd1;
      wr_o.first             = end_res;
      wr_o.first.last_result = 1'b1;
    end else begin
      wr_o.num   = 2'd0;
      wr_o.first = byte_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_MODE;
      fcnt_q   <= '0;
      fshift_q <= '0;
      mvar_q   <= 1'b0;
      count_q  <= '0;
      size_q   <= '0;
      done_q   <= '0;
      left_q   <= '0;
      trail_q  <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      fcnt_q   <= fcnt_d;
      fshift_q <= fshift_d;
      mvar_q   <= mvar_d;
      count_q  <= count_d;
      size_q   <= size_d;
      done_q   <= done_d;
      left_q   <= left_d;
      trail_q  <= trail_d;
    end
  end

endmodule

/* rtl/core/vld_checker.sv */
// Port-level checks on the value list deframer, bound to the top level.
// Depends on vld_pkg and value_list_deframer_macros.svh.
`timescale 1ns / 1ps
`include "value_list_deframer_macros.svh"

module vld_checker import vld_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [7:0]  data_byte_i,
  input logic        blob_end_i,
  input logic        no_byte_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  kind_o,
  input logic [7:0]  payload_byte_o,
  input logic [31:0] element_index_o,
  input logic        element_end_o,
  input logic [31:0] item_count_o,
  input logic [31:0] fixed_size_o,
  input logic        variable_mode_o,
  input logic [2:0]  error_code_o,
  input logic        last_result_o
);

  `VLD_ASSERT_HOLD(a_out_hold, out_valid_o, out_ready_i, kind_o, "result changed while stalled")
  `VLD_ASSERT(a_byte_only, (out_valid_o && kind_o != 3'(KIND_BYTE)) |-> (payload_byte_o == 8'd0), "payload byte on non-byte result")
  `VLD_ASSERT(a_empty_end, (out_valid_o && kind_o == 3'(KIND_EMPTY)) |-> element_end_o, "empty element without end mark")
  `VLD_ASSERT(a_end_last, (out_valid_o && (kind_o == 3'(KIND_ACCEPT) || kind_o == 3'(KIND_ERROR))) |-> last_result_o, "blob end result not last")

endmodule

bind value_list_deframer vld_checker u_vld_checker (.*);
